// ===== hdl/cbz_pkg.sv =====
// Shared constants and types for the cubic Bezier point evaluator.
`default_nettype none

package cbz_pkg;

    localparam int COORD_BITS_DEF  = 14;
    localparam int T_FRAC_BITS_DEF = 16;

    // t/u stage, first-level lerp, second products, partial sums, output
    localparam int NUM_STAGES = 5;
    localparam int NUM_REGS   = 8;
    localparam int REG_IDX_W  = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_P0_X = 3'd0,
        REG_P0_Y = 3'd1,
        REG_P1_X = 3'd2,
        REG_P1_Y = 3'd3,
        REG_P2_X = 3'd4,
        REG_P2_Y = 3'd5,
        REG_P3_X = 3'd6,
        REG_P3_Y = 3'd7
    } cbz_reg_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } cbz_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/cbz_ctrl.sv =====
// Valid/ready chain of the evaluation pipeline.
`default_nettype none

module cbz_ctrl
    import cbz_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output cbz_ctl_t      ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next = valid_reg;
        if (rdy[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign ctl.en    = rdy;

endmodule

`default_nettype wire

// ===== hdl/cbz_tu.sv =====
// Curve parameter stage: clamp t, form u = 1 - t, and carry both down the pipe.
`default_nettype none

module cbz_tu
    import cbz_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire cbz_ctl_t               ctl,
    input  wire logic [T_FRAC_BITS:0]   t_fraction,
    output logic [T_FRAC_BITS:0]        t_stage [3],
    output logic [T_FRAC_BITS:0]        u_stage [3]
);

    localparam int TW = T_FRAC_BITS + 1;
    localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

    logic [TW-1:0] t_sat;
    logic [TW-1:0] t_reg [3];
    logic [TW-1:0] u_reg [3];

    // clamp t above one
    assign t_sat = (t_fraction > T_ONE) ? T_ONE : t_fraction;

    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            t_reg[0] <= t_sat;
            u_reg[0] <= T_ONE - t_sat;
        end
        if (ctl.en[1])
        begin
            t_reg[1] <= t_reg[0];
            u_reg[1] <= u_reg[0];
        end
        if (ctl.en[2])
        begin
            t_reg[2] <= t_reg[1];
            u_reg[2] <= u_reg[1];
        end
    end

    assign t_stage = t_reg;
    assign u_stage = u_reg;

endmodule

`default_nettype wire

// ===== hdl/cbz_axis.sv =====
// One coordinate axis of the de Casteljau / Bernstein datapath.
`default_nettype none

module cbz_axis
    import cbz_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire cbz_ctl_t               ctl,
    input  wire logic [COORD_BITS-1:0]  p [4],
    input  wire logic [T_FRAC_BITS:0]   t_stage [3],
    input  wire logic [T_FRAC_BITS:0]   u_stage [3],
    output logic [COORD_BITS-1:0]       curve,
    output logic [COORD_BITS-1:0]       q [3],
    output logic [COORD_BITS-1:0]       r [2]
);

    localparam int C   = COORD_BITS;
    localparam int T   = T_FRAC_BITS;
    localparam int TW  = T + 1;
    localparam int AW  = T + C;           // first-level sums
    localparam int ASW = TW + C + 1;
    localparam int BW  = 2 * T + C;       // second-level sums
    localparam int BSW = AW + TW + 1;
    localparam int BL  = BW / 2;
    localparam int BH  = BW - BL;
    localparam int PLW = BL + TW;
    localparam int PHW = BH + TW;
    localparam int CW  = 3 * T + C;       // full Bernstein sum
    localparam int RSW = C + TW + 1;
    localparam logic [AW:0]   HALF_A = (AW + 1)'(1) << (T - 1);
    localparam logic [CW-1:0] HALF_C = CW'(1) << (3 * T - 1);

    logic [AW-1:0]  a_reg  [3];
    logic [C-1:0]   q2_reg [3];
    logic [BW-1:0]  b_reg  [2];
    logic [C-1:0]   q3_reg [3];
    logic [C-1:0]   r3_reg [2];
    logic [PLW-1:0] pl_reg;
    logic [PHW-1:0] ph_reg;
    logic [C-1:0]   curve_reg;
    logic [C-1:0]   q4_reg [3];
    logic [C-1:0]   r4_reg [2];

    logic [ASW-1:0] a_sum [3];
    logic [AW:0]    a_rnd [3];
    logic [BSW-1:0] b_sum [2];
    logic [RSW-1:0] r_sum [2];
    logic [PLW:0]   pl_sum;
    logic [PHW:0]   ph_sum;
    logic [CW-1:0]  c_sum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_sum[i] = ASW'(u_stage[0]) * ASW'(p[i]) + ASW'(t_stage[0]) * ASW'(p[i+1]);
            a_rnd[i] = (AW + 1)'(a_reg[i]) + HALF_A;
        end
        for (int j = 0; j < 2; j++)
        begin
            b_sum[j] = BSW'(a_reg[j]) * BSW'(u_stage[1])
                     + BSW'(a_reg[j+1]) * BSW'(t_stage[1]);
            r_sum[j] = RSW'(q2_reg[j]) * RSW'(u_stage[2])
                     + RSW'(q2_reg[j+1]) * RSW'(t_stage[2]);
        end
        // split the second-level sums so each multiply stays narrow
        pl_sum = (PLW + 1)'(b_reg[0][BL-1:0]) * (PLW + 1)'(u_stage[2])
               + (PLW + 1)'(b_reg[1][BL-1:0]) * (PLW + 1)'(t_stage[2]);
        ph_sum = (PHW + 1)'(b_reg[0][BW-1:BL]) * (PHW + 1)'(u_stage[2])
               + (PHW + 1)'(b_reg[1][BW-1:BL]) * (PHW + 1)'(t_stage[2]);
        c_sum  = (CW'(ph_reg) << BL) + CW'(pl_reg) + HALF_C;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_reg[i] <= a_sum[i][AW-1:0];
            end
        end
        if (ctl.en[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                q2_reg[i] <= a_rnd[i][T +: C];
            end
            for (int j = 0; j < 2; j++)
            begin
                b_reg[j] <= b_sum[j][BW-1:0];
            end
        end
        if (ctl.en[3])
        begin
            q3_reg <= q2_reg;
            for (int j = 0; j < 2; j++)
            begin
                r3_reg[j] <= r_sum[j][T +: C];
            end
            pl_reg <= pl_sum[PLW-1:0];
            ph_reg <= ph_sum[PHW-1:0];
        end
        if (ctl.en[4])
        begin
            q4_reg    <= q3_reg;
            r4_reg    <= r3_reg;
            curve_reg <= c_sum[3 * T +: C];
        end
    end

    assign curve = curve_reg;
    assign q     = q4_reg;
    assign r     = r4_reg;

endmodule

`default_nettype wire

// ===== hdl/cubic_bezier_point_evaluator.sv =====
// Cubic Bezier point evaluator top level: control point registers and pipeline.
// Pipeline: 5 register stages; a result shows on m_tvalid once its request has passed all five.
// Throughput: one request per cycle if m_tready is high; a stage moves when the next is free.
// Stall: m_tready low holds the output stage, bubbles ahead of it still fill.
// Reset: rst_n clears all stage valid bits and the control points to zero.
`default_nettype none

module cubic_bezier_point_evaluator
    import cbz_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // t_fraction
    input  wire logic [((T_FRAC_BITS + 8) / 8) * 8 - 1:0] s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // curve_x, curve_y, q1_x, q1_y, q2_x, q2_y, q3_x, q3_y, r1_x, r1_y, r2_x, r2_y
    output logic [((12 * COORD_BITS + 7) / 8) * 8 - 1:0]  m_tdata,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [REG_IDX_W-1:0]   cfg_index,
    input  wire logic [COORD_BITS-1:0]  cfg_data
);

    localparam int C     = COORD_BITS;
    localparam int OUT_W = ((12 * C + 7) / 8) * 8;

    logic [C-1:0]         cfg_reg [NUM_REGS];
    cbz_ctl_t             ctl;
    logic [T_FRAC_BITS:0] t_stage [3];
    logic [T_FRAC_BITS:0] u_stage [3];
    logic [C-1:0]         px [4];
    logic [C-1:0]         py [4];
    logic [C-1:0]         curve_x;
    logic [C-1:0]         curve_y;
    logic [C-1:0]         qx [3];
    logic [C-1:0]         qy [3];
    logic [C-1:0]         rx [2];
    logic [C-1:0]         ry [2];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign px[0] = cfg_reg[REG_P0_X];
    assign px[1] = cfg_reg[REG_P1_X];
    assign px[2] = cfg_reg[REG_P2_X];
    assign px[3] = cfg_reg[REG_P3_X];
    assign py[0] = cfg_reg[REG_P0_Y];
    assign py[1] = cfg_reg[REG_P1_Y];
    assign py[2] = cfg_reg[REG_P2_Y];
    assign py[3] = cfg_reg[REG_P3_Y];

    cbz_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    cbz_tu #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_tu
    (
        .clk        (clk),
        .ctl        (ctl),
        .t_fraction (s_tdata[T_FRAC_BITS:0]),
        .t_stage    (t_stage),
        .u_stage    (u_stage)
    );

    cbz_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_x
    (
        .clk     (clk),
        .ctl     (ctl),
        .p       (px),
        .t_stage (t_stage),
        .u_stage (u_stage),
        .curve   (curve_x),
        .q       (qx),
        .r       (rx)
    );

    cbz_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_axis_y
    (
        .clk     (clk),
        .ctl     (ctl),
        .p       (py),
        .t_stage (t_stage),
        .u_stage (u_stage),
        .curve   (curve_y),
        .q       (qy),
        .r       (ry)
    );

    assign m_tdata = OUT_W'({ry[1], rx[1], ry[0], rx[0],
                             qy[2], qx[2], qy[1], qx[1], qy[0], qx[0],
                             curve_y, curve_x});

endmodule

`default_nettype wire

// ===== dv/cubic_bezier_point_evaluator_tb.sv =====
// Self-checking testbench for the cubic Bezier point evaluator stream pipeline.
`timescale 1ns / 100ps

module cubic_bezier_point_evaluator_tb;
    import cbz_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int TW          = T_FRAC_BITS_DEF + 1;
    localparam int S_W         = ((T_FRAC_BITS_DEF + 8) / 8) * 8;
    localparam int M_W         = ((12 * COORD_BITS_DEF + 7) / 8) * 8;
    localparam int NUM_FIELDS  = 12;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [TW-1:0] T_ONE   = TW'(1) << T_FRAC_BITS_DEF;
    localparam logic [TW-1:0] T_MAXIN = '1;
    localparam logic [CW-1:0] C_MAX   = '1;

    // field 0 is curve_x, then curve_y, q1..q3 x/y, r1..r2 x/y
    typedef logic [NUM_FIELDS-1:0][CW-1:0] point_set_t;

    typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [TW-1:0] arg;    // register index or t
        logic [CW-1:0] value;
        bit            known;
        point_set_t    exp;
    } stim_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [M_W-1:0]   m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0]    cfg_data  = '0;

    logic [CW-1:0]    ctrl_pt [NUM_REGS];
    point_set_t       pending_points [$];
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               burst_left     = 0;

    string field_name [NUM_FIELDS] = '{"curve_x", "curve_y", "q1_x", "q1_y", "q2_x", "q2_y",
                                        "q3_x", "q3_y", "r1_x", "r1_y", "r2_x", "r2_y"};

    cubic_bezier_point_evaluator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Pack twelve coordinates given in output field order.
    function automatic point_set_t pack_points(input int cx, input int cy,
                                               input int q1x, input int q1y,
                                               input int q2x, input int q2y,
                                               input int q3x, input int q3y,
                                               input int r1x, input int r1y,
                                               input int r2x, input int r2y);
        point_set_t p;
        p[0]  = CW'(cx);
        p[1]  = CW'(cy);
        p[2]  = CW'(q1x);
        p[3]  = CW'(q1y);
        p[4]  = CW'(q2x);
        p[5]  = CW'(q2y);
        p[6]  = CW'(q3x);
        p[7]  = CW'(q3y);
        p[8]  = CW'(r1x);
        p[9]  = CW'(r1y);
        p[10] = CW'(r2x);
        p[11] = CW'(r2y);
        return p;
    endfunction

    // Bernstein point, first-level lerps rounded, second-level lerps truncated.
    function automatic point_set_t bezier_eval(input logic [TW-1:0] t_raw);
        point_set_t    res;
        logic [63:0]   t;
        logic [63:0]   u;
        logic [63:0]   a [3];
        logic [63:0]   q [3];
        logic [63:0]   b0;
        logic [63:0]   b1;
        logic [63:0]   c;
        logic [63:0]   p [4];
        t = (t_raw > T_ONE) ? 64'(T_ONE) : 64'(t_raw);
        u = 64'(T_ONE) - t;
        for (int ax = 0; ax < 2; ax++)
        begin
            for (int i = 0; i < 4; i++)
                p[i] = 64'(ctrl_pt[2 * i + ax]);
            for (int i = 0; i < 3; i++)
            begin
                a[i] = u * p[i] + t * p[i + 1];
                q[i] = (a[i] + (64'(T_ONE) >> 1)) >> T_FRAC_BITS_DEF;
                res[2 + 2 * i + ax] = q[i][CW-1:0];
            end
            res[8 + ax]  = CW'((u * q[0] + t * q[1]) >> T_FRAC_BITS_DEF);
            res[10 + ax] = CW'((u * q[1] + t * q[2]) >> T_FRAC_BITS_DEF);
            b0 = a[0] * u + a[1] * t;
            b1 = a[1] * u + a[2] * t;
            c  = b0 * u + b1 * t;
            c  = (c + (64'd1 << (3 * T_FRAC_BITS_DEF - 1))) >> (3 * T_FRAC_BITS_DEF);
            res[ax] = c[CW-1:0];
        end
        return res;
    endfunction

    function automatic void note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    // Registers change only with the pipeline empty.
    task automatic write_point_reg(input cbz_reg_t idx, input logic [CW-1:0] val);
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        ctrl_pt[idx] = val;
        burst_left = 0;
    endtask

    task automatic send_t(input logic [TW-1:0] t, input bit known, input point_set_t exp);
        if (cfg_valid)
            cfg_valid <= 1'b0;
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                      : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_W'(t);
        do
            @(posedge clk);
        while (!s_tready);
        pending_points.insert(pending_points.size(), known ? exp : bezier_eval(t));
        burst_left--;
    endtask

    function automatic logic [TW-1:0] random_t();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return '0;
                1:       return TW'(1);
                2:       return T_ONE - 1'b1;
                default: return T_ONE;
            endcase
        end
        if (sel <= 2)
            return TW'($urandom_range(int'(T_ONE) + 1, int'(T_MAXIN)));
        return TW'($urandom_range(0, int'(T_ONE)));
    endfunction

    stim_row_t dir_rows [35];

    initial
    begin
        point_set_t none;
        point_set_t all_max;
        point_set_t mix_t0;
        point_set_t mix_t1;
        logic [CW-1:0] val;
        none    = '0;
        all_max = '1;
        // control points (0,max) (max,0) (100,200) (max,max)
        mix_t0  = pack_points(0, C_MAX, 0, C_MAX, C_MAX, 0, 100, 200, 0, C_MAX, C_MAX, 0);
        mix_t1  = pack_points(C_MAX, C_MAX, C_MAX, 0, 100, 200, C_MAX, C_MAX,
                              100, 200, C_MAX, C_MAX);
        dir_rows = '{
            '{ROW_SAMPLE, '0,           '0,    1'b1, none},
            '{ROW_SAMPLE, T_ONE,        '0,    1'b1, none},
            '{ROW_SAMPLE, T_ONE >> 1,   '0,    1'b1, none},
            '{ROW_WRITE,  TW'(REG_P0_X), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P0_Y), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P1_X), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P1_Y), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P2_X), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P2_Y), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P3_X), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P3_Y), C_MAX, 1'b0, none},
            '{ROW_SAMPLE, '0,           '0,    1'b1, all_max},
            '{ROW_SAMPLE, TW'(1),       '0,    1'b1, all_max},
            '{ROW_SAMPLE, T_ONE >> 1,   '0,    1'b1, all_max},
            '{ROW_SAMPLE, T_ONE - 1'b1, '0,    1'b1, all_max},
            '{ROW_SAMPLE, T_ONE,        '0,    1'b1, all_max},
            '{ROW_SAMPLE, T_MAXIN,      '0,    1'b1, all_max},
            '{ROW_WRITE,  TW'(REG_P0_X), '0,    1'b0, none},
            '{ROW_WRITE,  TW'(REG_P0_Y), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P1_X), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P1_Y), '0,    1'b0, none},
            '{ROW_WRITE,  TW'(REG_P2_X), CW'(100), 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P2_Y), CW'(200), 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P3_X), C_MAX, 1'b0, none},
            '{ROW_WRITE,  TW'(REG_P3_Y), C_MAX, 1'b0, none},
            '{ROW_SAMPLE, '0,           '0,    1'b1, mix_t0},
            '{ROW_SAMPLE, T_ONE,        '0,    1'b1, mix_t1},
            // t above one saturates
            '{ROW_SAMPLE, T_ONE + 1'b1, '0,    1'b1, mix_t1},
            '{ROW_SAMPLE, T_MAXIN,      '0,    1'b1, mix_t1},
            '{ROW_SAMPLE, TW'('h15555), '0,    1'b1, mix_t1},
            '{ROW_SAMPLE, TW'(1),       '0,    1'b0, none},
            '{ROW_SAMPLE, T_ONE >> 1,   '0,    1'b0, none},
            '{ROW_SAMPLE, T_ONE - 1'b1, '0,    1'b0, none},
            '{ROW_SAMPLE, TW'(21845),   '0,    1'b0, none},
            '{ROW_SAMPLE, TW'('h0AAAA), '0,    1'b0, none}
        };
        for (int i = 0; i < NUM_REGS; i++)
            ctrl_pt[i] = '0;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_WRITE)
                write_point_reg(cbz_reg_t'(dir_rows[i].arg[REG_IDX_W-1:0]), dir_rows[i].value);
            else
                send_t(dir_rows[i].arg, dir_rows[i].known, dir_rows[i].exp);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            for (int r = 0; r < NUM_REGS; r++)
            begin
                case (phase % 4)
                    0:       val = CW'($urandom_range(0, int'(C_MAX)));
                    1:       val = $urandom_range(0, 1) ? C_MAX : '0;
                    2:       val = CW'($urandom_range(0, 15));
                    default: val = CW'($urandom_range(int'(C_MAX) - 15, int'(C_MAX)));
                endcase
                write_point_reg(cbz_reg_t'(r), val);
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_t(random_t(), 1'b0, none);
        end

        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        // catch any stray result still in the pipe
        repeat (4 * NUM_STAGES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Output stall pattern: switch between free-running, random and sparse modes.
    int stall_mode = 0;
    int mode_left  = 0;
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(32, 256);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk)
    begin : result_check
        point_set_t got;
        point_set_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = point_set_t'(m_tdata);
            if (pending_points.size() == 0)
                note_error($sformatf("result with no request pending: %h", got));
            else
            begin
                want = pending_points.pop_front();
                for (int f = 0; f < NUM_FIELDS; f++)
                    if (got[f] !== want[f])
                        note_error($sformatf("%s expected %0d got %0d",
                                             field_name[f], want[f], got[f]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hdl/cbz_pkg.sv
hdl/cbz_ctrl.sv
hdl/cbz_tu.sv
hdl/cbz_axis.sv
hdl/cubic_bezier_point_evaluator.sv
dv/cubic_bezier_point_evaluator_tb.sv
